// ===== sv/haversine_distance_core_assert.svh =====
// ----------------------------------------------------------------------------
// haversine distance core assertion macros
// concurrent checks clocked on clk and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_CORE_ASSERT_SVH
`define HAVERSINE_DISTANCE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// plain property, checked every cycle out of reset
`define HAV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition that must hold whenever the trigger is high
`define HAV_ASSERT_IMPLY(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

`else

`define HAV_ASSERT(label, prop, msg)
`define HAV_ASSERT_IMPLY(label, trig, cond, msg)

`endif

`endif

// ===== sv/hav_pkg.sv =====
// ----------------------------------------------------------------------------
// hav_pkg
// shared widths, fixed-point constants, cell data types and the atan table
// ----------------------------------------------------------------------------
`default_nettype none

package hav_pkg;

    // cordic datapath width, q2.30 plus headroom
    localparam int CW = 34;
    // integer square root: radicand and root widths
    localparam int SQ_RW = 61;
    localparam int SQ_W = 31;
    localparam int SQ_STEPS = 31;
    // radian scaling latency: partial products, then sum and round
    localparam int DIV_LAT = 2;

    localparam int RADIUS_W = 24;
    localparam int DIST_W = 26;
    localparam int ANG_W = 31;

    localparam logic [31:0] PI_Q30_U = 32'd3373259426;
    localparam logic signed [CW-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic [31:0] LAT_DIV = 32'd1800000000;
    localparam logic [31:0] HALF_DIV = 32'd3600000000;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_vec_t;

    typedef struct packed {
        logic [SQ_RW-1:0] rem;
        logic [SQ_W-1:0]  root;
    } sqrt_vec_t;

    // atan(2^-i) in q2.30
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] val;
        unique case (idx)
            0:  val = 32'h3243F6A8;
            1:  val = 32'h1DAC6705;
            2:  val = 32'h0FADBAFC;
            3:  val = 32'h07F56EA6;
            4:  val = 32'h03FEAB76;
            5:  val = 32'h01FFD55B;
            6:  val = 32'h00FFFAAA;
            7:  val = 32'h007FFF55;
            8:  val = 32'h003FFFEA;
            9:  val = 32'h001FFFFD;
            10: val = 32'h000FFFFF;
            11: val = 32'h0007FFFF;
            12: val = 32'h0003FFFF;
            13: val = 32'h0001FFFF;
            14: val = 32'h0000FFFF;
            15: val = 32'h00007FFF;
            16: val = 32'h00003FFF;
            17: val = 32'h00001FFF;
            18: val = 32'h00000FFF;
            19: val = 32'h000007FF;
            20: val = 32'h000003FF;
            21: val = 32'h000001FF;
            22: val = 32'h000000FF;
            23: val = 32'h0000007F;
            24: val = 32'h0000003F;
            25: val = 32'h0000001F;
            26: val = 32'h0000000F;
            27: val = 32'h00000008;
            28: val = 32'h00000004;
            29: val = 32'h00000002;
            30: val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== sv/hav_div_cell.sv =====
// ----------------------------------------------------------------------------
// hav_div_cell
// rounded magnitude * pi_q30 / divisor by reciprocal multiplication
// ----------------------------------------------------------------------------
`default_nettype none

module hav_div_cell #(
    parameter logic [31:0] DIVISOR = 32'd1800000000
) (
    input  logic        clk,
    input  logic [31:0] src,
    output logic [31:0] dst
);

    // ceil(pi_q30 * 2^65 / divisor); over any 32-bit magnitude the excess
    // stays below 2^-33, less than the 1/(2*divisor) grid of the exact value,
    // so adding one half and truncating rounds exactly
    localparam logic [97:0] NUM = 98'(hav_pkg::PI_Q30_U) << 65;
    localparam logic [97:0] RECIP_W = (NUM + 98'(DIVISOR) - 98'(1)) / 98'(DIVISOR);
    localparam logic [66:0] RECIP = RECIP_W[66:0];

    logic [63:0] pp_lo_reg;
    logic [63:0] pp_lo_next;
    logic [63:0] pp_mid_reg;
    logic [63:0] pp_mid_next;
    logic [34:0] pp_hi_reg;
    logic [34:0] pp_hi_next;
    logic [98:0] sum;
    logic [31:0] dst_next;

    always_comb
    begin
        pp_lo_next = 64'(src) * 64'(RECIP[31:0]);
        pp_mid_next = 64'(src) * 64'(RECIP[63:32]);
        pp_hi_next = 35'(src) * 35'(RECIP[66:64]);
        // plus one half of the quotient lsb
        sum = 99'(pp_lo_reg) + (99'(pp_mid_reg) << 32) + (99'(pp_hi_reg) << 64)
            + (99'(1) << 64);
        dst_next = sum[96:65];
    end

    always_ff @(posedge clk)
    begin
        pp_lo_reg <= pp_lo_next;
        pp_mid_reg <= pp_mid_next;
        pp_hi_reg <= pp_hi_next;
        dst <= dst_next;
    end

endmodule

`default_nettype wire

// ===== sv/hav_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// hav_cordic_cell
// one micro-rotation of a cordic, rotation or vectoring mode
// ----------------------------------------------------------------------------
`default_nettype none

module hav_cordic_cell #(
    parameter int SHIFT = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic                 clk,
    input  hav_pkg::cordic_vec_t src,
    output hav_pkg::cordic_vec_t dst
);

    localparam int W = hav_pkg::CW;
    localparam logic signed [W-1:0] ANG = $signed(W'(hav_pkg::atan_entry(SHIFT)));

    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic                up;
    hav_pkg::cordic_vec_t dst_next;

    always_comb
    begin
        xs = $signed(src.x) >>> SHIFT;
        ys = $signed(src.y) >>> SHIFT;
        // rotation follows the sign of z, vectoring drives y toward zero
        up = VECTOR ? ($signed(src.y) < 0) : ($signed(src.z) >= 0);
        if (up)
        begin
            dst_next.x = $signed(src.x) - ys;
            dst_next.y = $signed(src.y) + xs;
            dst_next.z = $signed(src.z) - ANG;
        end
        else
        begin
            dst_next.x = $signed(src.x) + ys;
            dst_next.y = $signed(src.y) - xs;
            dst_next.z = $signed(src.z) + ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        dst <= dst_next;
    end

endmodule

`default_nettype wire

// ===== sv/hav_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// hav_sqrt_cell
// one root bit of a digit-by-digit integer square root
// ----------------------------------------------------------------------------
`default_nettype none

module hav_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic               clk,
    input  hav_pkg::sqrt_vec_t src,
    output hav_pkg::sqrt_vec_t dst
);

    localparam int RW = hav_pkg::SQ_RW;
    localparam int QW = hav_pkg::SQ_W;
    localparam logic [RW:0] SQ_TERM = (RW+1)'(1) << (2 * BIT);

    // rem holds n - root^2; try (root + 2^bit)^2
    logic [RW:0] trial;
    logic [RW:0] rem_ext;
    hav_pkg::sqrt_vec_t dst_next;

    always_comb
    begin
        trial = ((RW+1)'(src.root) << (BIT + 1)) + SQ_TERM;
        rem_ext = {1'b0, src.rem};
        if (rem_ext >= trial)
        begin
            dst_next.rem = RW'(rem_ext - trial);
            dst_next.root = src.root | (QW'(1) << BIT);
        end
        else
        begin
            dst_next.rem = src.rem;
            dst_next.root = src.root;
        end
    end

    always_ff @(posedge clk)
    begin
        dst <= dst_next;
    end

endmodule

`default_nettype wire

// ===== sv/haversine_distance_core.sv =====
// ----------------------------------------------------------------------------
// haversine_distance_core
// great circle distance between two lat/lon points, fully pipelined
// ----------------------------------------------------------------------------
// Takes one point pair per clock: busy is always low, so every cycle with
// start high is a transaction. The result comes out on distance_m with done
// high for exactly one cycle, after the pair has passed through the whole
// pipeline; the receiver cannot stall it, so it must take every result as it
// appears. The main sections of the pipeline are the reciprocal radian
// scaling, the two cordic chains of CORDIC_STAGES cells and the 31-step square
// root. The radius register is written through cfg_valid/cfg_data (cfg_ready
// is always high) and must only change while no pair is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module haversine_distance_core #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [30:0]  start_latitude,
    input  logic signed [31:0]  start_longitude,
    input  logic signed [30:0]  end_latitude,
    input  logic signed [31:0]  end_longitude,
    output logic                done,
    output logic [25:0]         distance_m,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [23:0]         cfg_data
);

    localparam int N = CORDIC_STAGES;
    localparam int CW = hav_pkg::CW;
    localparam int DS = hav_pkg::DIV_LAT;
    localparam int SS = hav_pkg::SQ_STEPS;

    // valid bit positions along the pipeline
    localparam int V_IN = 0;
    localparam int V_DIV = V_IN + DS;
    localparam int V_RED = V_DIV + 1;
    localparam int V_SC = V_RED + N;
    localparam int V_FLIP = V_SC + 1;
    localparam int V_P1 = V_FLIP + 1;
    localparam int V_P2 = V_P1 + 1;
    localparam int V_A = V_P2 + 1;
    localparam int V_SQ = V_A + SS;
    localparam int V_VEC = V_SQ + N;
    localparam int V_RM = V_VEC + 1;
    localparam int V_OUT = V_RM + 1;
    localparam int V_TOT = V_OUT + 1;

    logic [V_TOT-1:0] vld_reg;
    logic [V_TOT-1:0] vld_next;
    logic [hav_pkg::RADIUS_W-1:0] radius_reg;
    logic [hav_pkg::RADIUS_W-1:0] radius_next;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;
    assign done = vld_reg[V_OUT];

    always_comb
    begin
        vld_next = {vld_reg[V_TOT-2:0], start};
        radius_next = cfg_valid ? cfg_data : radius_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            radius_reg <= hav_pkg::RADIUS_RESET;
        end
        else
        begin
            vld_reg <= vld_next;
            radius_reg <= radius_next;
        end
    end

    // ---------------- input: lanes lat1, lat2, dlat, dlon ----------------
    logic signed [32:0] ang_in [0:3];
    logic [31:0] mag_next [0:3];
    logic [3:0]  sgn_next;
    logic [31:0] mag_reg [0:3];
    logic [3:0]  sgn_reg [0:DS];

    always_comb
    begin
        ang_in[0] = 33'(start_latitude);
        ang_in[1] = 33'(end_latitude);
        ang_in[2] = 33'(end_latitude) - 33'(start_latitude);
        ang_in[3] = 33'(end_longitude) - 33'(start_longitude);
        for (int l = 0; l < 4; l++)
        begin
            sgn_next[l] = ang_in[l][32];
            mag_next[l] = ang_in[l][32] ? 32'(-ang_in[l]) : 32'(ang_in[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            mag_reg[l] <= mag_next[l];
        end
        sgn_reg[0] <= sgn_next;
        for (int k = 1; k <= DS; k++)
        begin
            sgn_reg[k] <= sgn_reg[k-1];
        end
    end

    // ---------------- radian scaling by reciprocal ----------------
    logic [31:0] quo [0:3];

    for (genvar l = 0; l < 4; l++)
    begin : g_div_lane
        hav_div_cell #(
            .DIVISOR((l < 2) ? hav_pkg::LAT_DIV : hav_pkg::HALF_DIV)
        ) u_div (
            .clk (clk),
            .src (mag_reg[l]),
            .dst (quo[l])
        );
    end

    // ---------------- sign and range reduction ----------------
    logic signed [CW-1:0] th_next [0:3];
    logic [3:0] flip_next;
    hav_pkg::cordic_vec_t red_reg [0:3];
    logic [3:0] flip_reg [0:N];
    hav_pkg::cordic_vec_t sc_vec [0:3][0:N];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            th_next[l] = sgn_reg[DS][l] ? -$signed({2'b00, quo[l]})
                                        : $signed({2'b00, quo[l]});
            flip_next[l] = 1'b0;
            if (th_next[l] > hav_pkg::HALF_PI_Q30)
            begin
                th_next[l] = th_next[l] - hav_pkg::PI_Q30;
                flip_next[l] = 1'b1;
            end
            else if (th_next[l] < -hav_pkg::HALF_PI_Q30)
            begin
                th_next[l] = th_next[l] + hav_pkg::PI_Q30;
                flip_next[l] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            red_reg[l].x <= hav_pkg::INV_GAIN_Q30;
            red_reg[l].y <= '0;
            red_reg[l].z <= th_next[l];
        end
        flip_reg[0] <= flip_next;
        for (int k = 1; k <= N; k++)
        begin
            flip_reg[k] <= flip_reg[k-1];
        end
    end

    // ---------------- sin/cos cordic chains ----------------
    for (genvar l = 0; l < 4; l++)
    begin : g_sc_lane
        assign sc_vec[l][0] = red_reg[l];
        for (genvar k = 0; k < N; k++)
        begin : g_sc_step
            hav_cordic_cell #(
                .SHIFT  (k),
                .VECTOR (1'b0)
            ) u_cell (
                .clk (clk),
                .src (sc_vec[l][k]),
                .dst (sc_vec[l][k+1])
            );
        end
    end

    // ---------------- haversine term ----------------
    // lanes 0,1 give cos of the latitudes, lanes 2,3 sin of the half deltas
    logic signed [CW-1:0] trig_reg [0:3];
    logic signed [CW-1:0] cc_reg;
    logic signed [CW-1:0] sl2_reg;
    logic signed [CW-1:0] so2_reg;
    logic signed [CW-1:0] sl2_d_reg;
    logic signed [CW-1:0] t_reg;
    logic [30:0] a_reg;
    logic signed [2*CW-1:0] p_cc;
    logic signed [2*CW-1:0] p_sl;
    logic signed [2*CW-1:0] p_so;
    logic signed [2*CW-1:0] p_t;
    logic signed [CW:0] a_sum;
    logic [30:0] a_next;

    always_comb
    begin
        p_cc = trig_reg[0] * trig_reg[1];
        p_sl = trig_reg[2] * trig_reg[2];
        p_so = trig_reg[3] * trig_reg[3];
        p_t = cc_reg * so2_reg;
        a_sum = {sl2_d_reg[CW-1], sl2_d_reg} + {t_reg[CW-1], t_reg};
        // clamp a into [0, 1]
        if (a_sum < 0)
        begin
            a_next = '0;
        end
        else if (a_sum > $signed({4'b0000, hav_pkg::ONE_Q30}))
        begin
            a_next = hav_pkg::ONE_Q30;
        end
        else
        begin
            a_next = a_sum[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            trig_reg[l] <= flip_reg[N][l] ? -$signed(sc_vec[l][N].x) : $signed(sc_vec[l][N].x);
        end
        for (int l = 2; l < 4; l++)
        begin
            trig_reg[l] <= flip_reg[N][l] ? -$signed(sc_vec[l][N].y) : $signed(sc_vec[l][N].y);
        end
        cc_reg <= p_cc[CW+29:30];
        sl2_reg <= p_sl[CW+29:30];
        so2_reg <= p_so[CW+29:30];
        sl2_d_reg <= sl2_reg;
        t_reg <= p_t[CW+29:30];
        a_reg <= a_next;
    end

    // ---------------- square roots of a and 1-a ----------------
    hav_pkg::sqrt_vec_t sq_vec [0:1][0:SS];
    logic [30:0] b_val;

    assign b_val = hav_pkg::ONE_Q30 - a_reg;
    assign sq_vec[0][0].rem = {a_reg, 30'b0};
    assign sq_vec[0][0].root = '0;
    assign sq_vec[1][0].rem = {b_val, 30'b0};
    assign sq_vec[1][0].root = '0;

    for (genvar r = 0; r < 2; r++)
    begin : g_sq_lane
        for (genvar k = 0; k < SS; k++)
        begin : g_sq_step
            hav_sqrt_cell #(
                .BIT (SS - 1 - k)
            ) u_cell (
                .clk (clk),
                .src (sq_vec[r][k]),
                .dst (sq_vec[r][k+1])
            );
        end
    end

    // ---------------- atan2 by vectoring ----------------
    hav_pkg::cordic_vec_t vc_vec [0:N];

    assign vc_vec[0].x = CW'(sq_vec[1][SS].root);
    assign vc_vec[0].y = CW'(sq_vec[0][SS].root);
    assign vc_vec[0].z = '0;

    for (genvar k = 0; k < N; k++)
    begin : g_vc_step
        hav_cordic_cell #(
            .SHIFT  (k),
            .VECTOR (1'b1)
        ) u_cell (
            .clk (clk),
            .src (vc_vec[k]),
            .dst (vc_vec[k+1])
        );
    end

    // ---------------- scale by radius ----------------
    localparam int PW = hav_pkg::RADIUS_W + hav_pkg::ANG_W;

    logic [hav_pkg::ANG_W-1:0] ang;
    logic [PW-1:0] rm_reg;
    logic [hav_pkg::DIST_W-1:0] dist_reg;

    // angle below zero clamps to zero
    assign ang = ($signed(vc_vec[N].z) < 0) ? '0 : vc_vec[N].z[hav_pkg::ANG_W-1:0];

    always_ff @(posedge clk)
    begin
        rm_reg <= PW'(radius_reg) * PW'(ang);
        // radius times angle over 2^29 always fits the output width
        dist_reg <= rm_reg[PW-1:29];
    end

    assign distance_m = dist_reg;

    `include "haversine_distance_core_assert.svh"

    `HAV_ASSERT_IMPLY(a_clamp_range, vld_reg[V_A], a_reg <= hav_pkg::ONE_Q30,
        "haversine term left the unit interval")

    `HAV_ASSERT_IMPLY(a_reduced_angle, vld_reg[V_RED],
        ($signed(red_reg[0].z) <= hav_pkg::HALF_PI_Q30) &&
        ($signed(red_reg[0].z) >= -hav_pkg::HALF_PI_Q30) &&
        ($signed(red_reg[3].z) <= hav_pkg::HALF_PI_Q30) &&
        ($signed(red_reg[3].z) >= -hav_pkg::HALF_PI_Q30),
        "range reduction left an angle outside half pi")

    `HAV_ASSERT_IMPLY(a_root_range, vld_reg[V_SQ],
        (sq_vec[0][SS].root <= hav_pkg::ONE_Q30) &&
        (sq_vec[1][SS].root <= hav_pkg::ONE_Q30),
        "square root above one")

endmodule

`default_nettype wire
